// ===== sv/rsvg_pkg.sv =====
// Shared constants for the rope strip vertex generator.
// Item kinds, register indexes and field widths; no dependencies.
package rsvg_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [KindW-1:0] KIND_START  = 2'd0;
  localparam logic [KindW-1:0] KIND_LINK   = 2'd1;
  localparam logic [KindW-1:0] KIND_FINISH = 2'd2;

  localparam logic [RegIdxW-1:0] REG_CAMERA_X      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CAMERA_Y      = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CAMERA_Z      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_FIXED_FWD_X   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_FIXED_FWD_Y   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_FIXED_FWD_Z   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_USE_FIXED_FWD = 3'd6;
  localparam logic [RegIdxW-1:0] REG_TEXTURE_STEP  = 3'd7;

  localparam logic [CoordW-1:0] FIXED_FWD_Z_RESET  = 32'h0001_0000;
  localparam logic [CoordW-1:0] TEXTURE_STEP_RESET = 32'h0001_0000;

endpackage

// ===== sv/rsvg_if.sv =====
// Valid/ready stream interfaces for rope points in and strip vertices out.
// Depends on rsvg_pkg.
interface rsvg_point_if
  import rsvg_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;
  logic [CoordW-1:0]        rope_width;

  modport source (output valid, kind, point_x, point_y, point_z, rope_width, input ready);
  modport sink   (input valid, kind, point_x, point_y, point_z, rope_width, output ready);
endinterface

interface rsvg_vertex_if
  import rsvg_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic signed [CoordW-1:0] vertex_z;
  logic                     tex_u;
  logic [CoordW-1:0]        tex_v;
  logic                     last;

  modport source (output valid, vertex_x, vertex_y, vertex_z, tex_u, tex_v, last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, tex_u, tex_v, last, output ready);
endinterface

// ===== sv/rope_strip_vertex_generator_unit.sv =====
// Rope strip vertex generator: rope points in, camera-facing strip vertices out.
// Depends on rsvg_pkg and the stream interfaces in rsvg_if.sv.
//
// Channels: rope_in takes items of kind start, link or finish; vtx_out gives
// strip vertices. Both move one item per transfer on valid and ready high.
// wr_en/wr_index/wr_data write the camera, fixed forward, mode and texture
// step registers; write them only while the block is idle.
// A start item gives no vertex. A link or finish item runs through one
// shared multiplier, a bit-pair square root loop and a restoring divider,
// under a sequencer. Each vector normalization takes a square root and
// three divisions, and the first link of a rope also works out the side
// vector at its start point. rope_in is ready only while the sequencer
// idles. Vertices leave through an output register; when the receiver
// stalls the sequencer holds on the waiting vertex. Reset restores the
// register defaults, clears the rope state and arms the first-link flag.
module rope_strip_vertex_generator_unit
  import rsvg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  rsvg_point_if.sink          rope_in,
  rsvg_vertex_if.source       vtx_out,
  input  logic                wr_en,
  input  logic [RegIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NLOAD  = 4'd1;
  localparam logic [3:0] S_NSHIFT = 4'd2;
  localparam logic [3:0] S_SQ_M   = 4'd3;
  localparam logic [3:0] S_SQ_A   = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_DLOAD  = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_NDONE  = 4'd8;
  localparam logic [3:0] S_CR_M   = 4'd9;
  localparam logic [3:0] S_CR_A   = 4'd10;
  localparam logic [3:0] S_SC_M   = 4'd11;
  localparam logic [3:0] S_SC_A   = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  localparam logic [2:0] PH_VIEW  = 3'd0;
  localparam logic [2:0] PH_UP    = 3'd1;
  localparam logic [2:0] PH_RSIDE = 3'd2;
  localparam logic [2:0] PH_LVIEW = 3'd3;
  localparam logic [2:0] PH_LSIDE = 3'd4;

  logic signed [CoordW-1:0] cam [3];
  logic signed [CoordW-1:0] ffwd [3];
  logic                     use_fixed;
  logic [CoordW-1:0]        tex_step;

  logic signed [CoordW-1:0] prev [3];
  logic signed [CoordW-1:0] pt [3];
  logic [CoordW-2:0]        half_width;
  logic [CoordW-1:0]        tex_offset;
  logic                     first_link;
  logic                     finish;

  logic [3:0]               state;
  logic [2:0]               phase;
  logic [2:0]               idx;
  logic [1:0]               emit_idx;

  logic signed [63:0]       vec [3];
  logic [62:0]              mg [3];
  logic [2:0]               sgn;
  logic [62:0]              mx;
  logic [63:0]              acc;
  logic [63:0]              sq_x;
  logic [63:0]              sq_r;
  logic [63:0]              sq_bit;
  logic [63:0]              sq_t;
  logic [63:0]              sq_r_next;
  logic                     sq_ge;
  logic [31:0]              len;
  logic [31:0]              rem;
  logic [16:0]              nb;
  logic [16:0]              quo;
  logic [4:0]               dcnt;
  logic [32:0]              div_t;
  logic                     div_ge;
  logic [16:0]              q_final;

  logic signed [17:0]       nrm [3];
  logic signed [32:0]       fwd [3];
  logic signed [17:0]       up [3];
  logic signed [31:0]       right [3];
  logic signed [31:0]       lr [3];
  logic signed [17:0]       n_sel;
  logic [16:0]              n_mag;
  logic [31:0]              p_mag;

  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       prod;

  logic                     out_valid;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] out_z;
  logic                     out_u;
  logic [CoordW-1:0]        out_v;
  logic                     out_last;
  logic signed [CoordW-1:0] vx [3];
  logic [CoordW-1:0]        tex_next;
  logic                     in_xfer;

  function automatic logic signed [63:0] diff64(logic signed [31:0] a, logic signed [31:0] b);
    diff64 = 64'(33'(a) - 33'(b));
  endfunction

  assign in_xfer       = rope_in.valid && rope_in.ready;
  assign rope_in.ready = (state == S_IDLE);
  assign tex_next      = tex_offset + tex_step;

  assign vtx_out.valid    = out_valid;
  assign vtx_out.vertex_x = out_x;
  assign vtx_out.vertex_y = out_y;
  assign vtx_out.vertex_z = out_z;
  assign vtx_out.tex_u    = out_u;
  assign vtx_out.tex_v    = out_v;
  assign vtx_out.last     = out_last;

  always_comb begin
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
  end

  always_comb begin
    sq_t      = sq_r + sq_bit;
    sq_ge     = (sq_x >= sq_t);
    sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
    div_t     = {rem, nb[16]};
    div_ge    = (div_t >= {1'b0, len});
    q_final   = {quo[15:0], div_ge};
    n_sel     = nrm[idx[1:0]];
    n_mag     = n_sel[17] ? 17'(-n_sel) : n_sel[16:0];
    p_mag     = prod[47:16];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ_M: begin
        mul_a = $signed({2'b0, mg[idx[1:0]][30:0]});
        mul_b = $signed({2'b0, mg[idx[1:0]][30:0]});
      end
      S_CR_M: begin
        case (idx)
          3'd0: begin mul_a = fwd[1]; mul_b = 33'(up[2]); end
          3'd1: begin mul_a = fwd[2]; mul_b = 33'(up[1]); end
          3'd2: begin mul_a = fwd[2]; mul_b = 33'(up[0]); end
          3'd3: begin mul_a = fwd[0]; mul_b = 33'(up[2]); end
          3'd4: begin mul_a = fwd[0]; mul_b = 33'(up[1]); end
          default: begin mul_a = fwd[1]; mul_b = 33'(up[0]); end
        endcase
      end
      S_SC_M: begin
        mul_a = $signed({16'b0, n_mag});
        mul_b = $signed({2'b0, half_width});
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (emit_idx[1]) begin
        vx[i] = (emit_idx == 2'd3) ? pt[i] + right[i] : pt[i] - right[i];
      end else begin
        vx[i] = (emit_idx == 2'd0) ? prev[i] + lr[i] : prev[i] - lr[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cam[0]    <= '0;
      cam[1]    <= '0;
      cam[2]    <= '0;
      ffwd[0]   <= '0;
      ffwd[1]   <= '0;
      ffwd[2]   <= $signed(FIXED_FWD_Z_RESET);
      use_fixed <= 1'b0;
      tex_step  <= TEXTURE_STEP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CAMERA_X:      cam[0]    <= $signed(wr_data);
        REG_CAMERA_Y:      cam[1]    <= $signed(wr_data);
        REG_CAMERA_Z:      cam[2]    <= $signed(wr_data);
        REG_FIXED_FWD_X:   ffwd[0]   <= $signed(wr_data);
        REG_FIXED_FWD_Y:   ffwd[1]   <= $signed(wr_data);
        REG_FIXED_FWD_Z:   ffwd[2]   <= $signed(wr_data);
        REG_USE_FIXED_FWD: use_fixed <= wr_data[0];
        REG_TEXTURE_STEP:  tex_step  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_VIEW;
      idx        <= '0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
      prev[0]    <= '0;
      prev[1]    <= '0;
      prev[2]    <= '0;
      half_width <= '0;
      tex_offset <= '0;
      first_link <= 1'b1;
    end else begin
      if (state != S_EMIT && out_valid && vtx_out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (rope_in.kind == KIND_START) begin
              prev[0]    <= rope_in.point_x;
              prev[1]    <= rope_in.point_y;
              prev[2]    <= rope_in.point_z;
              half_width <= rope_in.rope_width[CoordW-1:1];
              tex_offset <= '0;
              first_link <= 1'b1;
            end else if (rope_in.kind == KIND_LINK || rope_in.kind == KIND_FINISH) begin
              pt[0]  <= rope_in.point_x;
              pt[1]  <= rope_in.point_y;
              pt[2]  <= rope_in.point_z;
              finish <= (rope_in.kind == KIND_FINISH);
              state  <= S_NLOAD;
              if (use_fixed) begin
                for (int i = 0; i < 3; i++) fwd[i] <= 33'(ffwd[i]);
                phase  <= PH_UP;
                vec[0] <= diff64(rope_in.point_x, prev[0]);
                vec[1] <= diff64(rope_in.point_y, prev[1]);
                vec[2] <= diff64(rope_in.point_z, prev[2]);
              end else begin
                phase  <= PH_VIEW;
                vec[0] <= diff64(rope_in.point_x, cam[0]);
                vec[1] <= diff64(rope_in.point_y, cam[1]);
                vec[2] <= diff64(rope_in.point_z, cam[2]);
              end
            end
          end
        end
        S_NLOAD: begin
          for (int i = 0; i < 3; i++) begin
            mg[i]  <= vec[i][63] ? 63'(-vec[i]) : vec[i][62:0];
            sgn[i] <= vec[i][63];
          end
          state <= S_NSHIFT;
        end
        S_NSHIFT: begin
          if (mx == '0) begin
            for (int i = 0; i < 3; i++) nrm[i] <= '0;
            state <= S_NDONE;
          end else if (mx < (63'd1 << 22)) begin
            for (int i = 0; i < 3; i++) mg[i] <= mg[i] << 8;
          end else if (mx < (63'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mg[i] <= mg[i] << 1;
          end else if (mx >= (63'd1 << 39)) begin
            for (int i = 0; i < 3; i++) mg[i] <= mg[i] >> 8;
          end else if (mx >= (63'd1 << 31)) begin
            for (int i = 0; i < 3; i++) mg[i] <= mg[i] >> 1;
          end else begin
            acc   <= '0;
            idx   <= '0;
            state <= S_SQ_M;
          end
        end
        S_SQ_M: state <= S_SQ_A;
        S_SQ_A: begin
          acc <= acc + prod[63:0];
          if (idx == 3'd2) begin
            sq_x   <= acc + prod[63:0];
            sq_r   <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= S_SQRT;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_SQ_M;
          end
        end
        S_SQRT: begin
          if (sq_ge) sq_x <= sq_x - sq_t;
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            len   <= sq_r_next[31:0];
            idx   <= '0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          rem   <= 32'(mg[idx[1:0]][30:1]);
          nb    <= {mg[idx[1:0]][0], 16'b0};
          quo   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= div_ge ? 32'(div_t - {1'b0, len}) : div_t[31:0];
          quo  <= q_final;
          nb   <= nb << 1;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd16) begin
            nrm[idx[1:0]] <= sgn[idx[1:0]] ? -$signed({1'b0, q_final})
                                           : $signed({1'b0, q_final});
            if (idx == 3'd2) begin
              state <= S_NDONE;
            end else begin
              idx   <= idx + 3'd1;
              state <= S_DLOAD;
            end
          end
        end
        S_NDONE: begin
          idx <= '0;
          case (phase)
            PH_VIEW: begin
              for (int i = 0; i < 3; i++) fwd[i] <= 33'(nrm[i]);
              vec[0] <= diff64(pt[0], prev[0]);
              vec[1] <= diff64(pt[1], prev[1]);
              vec[2] <= diff64(pt[2], prev[2]);
              phase  <= PH_UP;
              state  <= S_NLOAD;
            end
            PH_UP: begin
              for (int i = 0; i < 3; i++) up[i] <= nrm[i];
              phase <= PH_RSIDE;
              state <= S_CR_M;
            end
            PH_LVIEW: begin
              for (int i = 0; i < 3; i++) fwd[i] <= 33'(nrm[i]);
              phase <= PH_LSIDE;
              state <= S_CR_M;
            end
            default: state <= S_SC_M;
          endcase
        end
        S_CR_M: state <= S_CR_A;
        S_CR_A: begin
          vec[idx[2:1]] <= idx[0] ? vec[idx[2:1]] - prod[63:0] : prod[63:0];
          if (idx == 3'd5) begin
            idx   <= '0;
            state <= S_NLOAD;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_CR_M;
          end
        end
        S_SC_M: state <= S_SC_A;
        S_SC_A: begin
          if (phase == PH_RSIDE) begin
            right[idx[1:0]] <= n_sel[17] ? -$signed(p_mag) : $signed(p_mag);
          end else begin
            lr[idx[1:0]] <= n_sel[17] ? -$signed(p_mag) : $signed(p_mag);
          end
          if (idx == 3'd2) begin
            idx <= '0;
            if (phase == PH_RSIDE && first_link) begin
              vec[0] <= diff64(prev[0], cam[0]);
              vec[1] <= diff64(prev[1], cam[1]);
              vec[2] <= diff64(prev[2], cam[2]);
              phase  <= PH_LVIEW;
              state  <= S_NLOAD;
            end else begin
              emit_idx <= (phase == PH_RSIDE) ? 2'd2 : 2'd0;
              state    <= S_EMIT;
            end
          end else begin
            idx   <= idx + 3'd1;
            state <= S_SC_M;
          end
        end
        S_EMIT: begin
          if (!out_valid || vtx_out.ready) begin
            out_valid <= 1'b1;
            out_x     <= vx[0];
            out_y     <= vx[1];
            out_z     <= vx[2];
            out_u     <= (emit_idx == 2'd1) || (emit_idx == 2'd2);
            out_v     <= emit_idx[1] ? tex_next : tex_offset;
            out_last  <= (emit_idx == 2'd3) && finish;
            if (emit_idx == 2'd3) begin
              prev[0]    <= pt[0];
              prev[1]    <= pt[1];
              prev[2]    <= pt[2];
              tex_offset <= tex_next;
              first_link <= 1'b0;
              state      <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (len != '0))
    else $error("divide step with zero length");

  a_busy_after_link: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (rope_in.kind == KIND_LINK || rope_in.kind == KIND_FINISH))
      |=> !rope_in.ready)
    else $error("ready while a link is in work");

  a_last_is_plus_side: assert property (@(posedge clk) disable iff (rst)
    (vtx_out.valid && vtx_out.last) |-> !vtx_out.tex_u)
    else $error("last vertex with u set");

endmodule
